[hdl/dso4_pkg.sv]
// Shared constants, types and helpers of the 4D diagonal scan order unit.
// Used by the register file, the walk unit, the offset unit and the top level.
// No dependencies.
`default_nettype none

package dso4_pkg;

    localparam int MAX_DIM   = 64;
    localparam int NUM_AXES  = 4;
    localparam int SIZE_W    = 7;
    localparam int STRIDE_W  = 24;
    localparam int OFFSET_W  = 32;
    localparam int COORD_W   = 6;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = 3;

    // Clamped limit holds 1..MAX_DIM.
    localparam int LIM_W  = $clog2(MAX_DIM + 1);
    // Walk coordinates hold any sum up to one past the largest coordinate sum.
    localparam int WALK_W = $clog2(4 * MAX_DIM) + 1;
    localparam int SUM_W  = WALK_W + 2;
    localparam int PROD_W = WALK_W + STRIDE_W;
    localparam int STEP_W = $clog2(NUM_AXES + 1);

    // Register indexes on the configuration port.
    localparam logic [REG_IDX_W-1:0] REG_SIZE_X   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_Y   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_U   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_V   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STRIDE_X = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_STRIDE_Y = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_STRIDE_U = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_STRIDE_V = 3'd7;

    // Operations of the walk unit.
    localparam logic [1:0] WOP_HOLD = 2'd0;
    localparam logic [1:0] WOP_ZERO = 2'd1;
    localparam logic [1:0] WOP_STEP = 2'd2;

    typedef logic [NUM_AXES-1:0][WALK_W-1:0] coord_vec_t;

    typedef struct packed {
        logic [NUM_AXES-1:0][SIZE_W-1:0]   size;
        logic [NUM_AXES-1:0][STRIDE_W-1:0] stride;
    } cfg_t;

    typedef struct packed {
        logic [1:0] op;
    } walk_cmd_t;

    typedef struct packed {
        logic in_range;
        logic over;
    } walk_stat_t;

    // A size of zero acts as one, a size above MAX_DIM acts as MAX_DIM.
    function automatic logic [LIM_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
        if (s == '0)
        begin
            return LIM_W'(1);
        end
        if (int'(s) > MAX_DIM)
        begin
            return LIM_W'(MAX_DIM);
        end
        return LIM_W'(s);
    endfunction

endpackage

`default_nettype wire

[hdl/dso4_cfg.sv]
// Configuration register file behind the APB-style port: block sizes and strides.
// Depends on dso4_pkg.
`default_nettype none

module dso4_cfg (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [dso4_pkg::ADDR_W-1:0]   paddr,
    input  wire  [dso4_pkg::DATA_W-1:0]   pwdata,
    output logic [dso4_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output dso4_pkg::cfg_t                cfg
);
    import dso4_pkg::*;

    logic [NUM_AXES-1:0][SIZE_W-1:0]   size_reg;
    logic [NUM_AXES-1:0][STRIDE_W-1:0] stride_reg;
    logic [REG_IDX_W-1:0]              idx;
    logic                              wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg[0]   <= SIZE_W'(15);
            size_reg[1]   <= SIZE_W'(15);
            size_reg[2]   <= SIZE_W'(13);
            size_reg[3]   <= SIZE_W'(13);
            stride_reg[0] <= STRIDE_W'(1);
            stride_reg[1] <= STRIDE_W'(15);
            stride_reg[2] <= STRIDE_W'(225);
            stride_reg[3] <= STRIDE_W'(2925);
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_SIZE_X:   size_reg[0]   <= pwdata[SIZE_W-1:0];
                REG_SIZE_Y:   size_reg[1]   <= pwdata[SIZE_W-1:0];
                REG_SIZE_U:   size_reg[2]   <= pwdata[SIZE_W-1:0];
                REG_SIZE_V:   size_reg[3]   <= pwdata[SIZE_W-1:0];
                REG_STRIDE_X: stride_reg[0] <= pwdata[STRIDE_W-1:0];
                REG_STRIDE_Y: stride_reg[1] <= pwdata[STRIDE_W-1:0];
                REG_STRIDE_U: stride_reg[2] <= pwdata[STRIDE_W-1:0];
                REG_STRIDE_V: stride_reg[3] <= pwdata[STRIDE_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SIZE_X:   prdata = DATA_W'(size_reg[0]);
            REG_SIZE_Y:   prdata = DATA_W'(size_reg[1]);
            REG_SIZE_U:   prdata = DATA_W'(size_reg[2]);
            REG_SIZE_V:   prdata = DATA_W'(size_reg[3]);
            REG_STRIDE_X: prdata = DATA_W'(stride_reg[0]);
            REG_STRIDE_Y: prdata = DATA_W'(stride_reg[1]);
            REG_STRIDE_U: prdata = DATA_W'(stride_reg[2]);
            REG_STRIDE_V: prdata = DATA_W'(stride_reg[3]);
            default:      prdata = '0;
        endcase
    end

    assign cfg.size   = size_reg;
    assign cfg.stride = stride_reg;

endmodule

`default_nettype wire

[hdl/dso4_walk.sv]
// Walk unit: holds the scan position and moves it one tuple per step command.
// Depends on dso4_pkg.
`default_nettype none

module dso4_walk (
    input  wire                    clk,
    input  wire                    rst_n,
    input  dso4_pkg::cfg_t         cfg,
    input  dso4_pkg::walk_cmd_t    cmd,
    output dso4_pkg::coord_vec_t   pos,
    output dso4_pkg::walk_stat_t   stat
);
    import dso4_pkg::*;

    coord_vec_t                      pos_reg;
    coord_vec_t                      pos_next;
    coord_vec_t                      stepped;
    logic [NUM_AXES-1:0][LIM_W-1:0]  lim;
    logic [SUM_W-1:0]                lim_sum;
    logic [SUM_W-1:0]                max_sum;
    logic [SUM_W-1:0]                pos_sum;
    logic [NUM_AXES-1:0]             axis_ok;

    always_comb
    begin
        lim_sum = '0;
        pos_sum = '0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            lim[i]     = clamp_size(cfg.size[i]);
            lim_sum    = lim_sum + SUM_W'(lim[i]);
            pos_sum    = pos_sum + SUM_W'(pos_reg[i]);
            axis_ok[i] = pos_reg[i] < WALK_W'(lim[i]);
        end
        // Every limit is at least one, so this never goes below zero.
        max_sum = lim_sum - SUM_W'(NUM_AXES);
    end

    assign stat.in_range = &axis_ok;
    assign stat.over     = pos_sum > max_sum;

    // One unit moves from the lowest nonzero of x, y, u to the next axis up and the
    // rest of it to x; with x, y and u all zero the next diagonal opens at x = v + 1.
    always_comb
    begin
        stepped = pos_reg;
        if (pos_reg[0] != '0)
        begin
            stepped[1] = pos_reg[1] + WALK_W'(1);
            stepped[0] = pos_reg[0] - WALK_W'(1);
        end
        else if (pos_reg[1] != '0)
        begin
            stepped[2] = pos_reg[2] + WALK_W'(1);
            stepped[0] = pos_reg[1] - WALK_W'(1);
            stepped[1] = '0;
        end
        else if (pos_reg[2] != '0)
        begin
            stepped[3] = pos_reg[3] + WALK_W'(1);
            stepped[0] = pos_reg[2] - WALK_W'(1);
            stepped[2] = '0;
        end
        else
        begin
            stepped[0] = pos_reg[3] + WALK_W'(1);
            stepped[3] = '0;
        end
    end

    always_comb
    begin
        unique case (cmd.op)
            WOP_ZERO: pos_next = '0;
            WOP_STEP: pos_next = stepped;
            default:  pos_next = pos_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    assign pos = pos_reg;

endmodule

`default_nettype wire

[hdl/dso4_mac.sv]
// Offset unit: one shared multiplier and accumulator that sums coordinate
// times stride over the four axes, one axis per cycle. Depends on dso4_pkg.
`default_nettype none

module dso4_mac (
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             start,
    input  dso4_pkg::coord_vec_t            coords,
    input  dso4_pkg::cfg_t                  cfg,
    output logic                            busy,
    output dso4_pkg::coord_vec_t            em_coords,
    output logic [dso4_pkg::OFFSET_W-1:0]   acc
);
    import dso4_pkg::*;

    logic                 busy_reg;
    logic [STEP_W-1:0]    step_reg;
    coord_vec_t           em_reg;
    logic [OFFSET_W-1:0]  prod_reg;
    logic [OFFSET_W-1:0]  acc_reg;
    logic [1:0]           sel;
    logic [PROD_W-1:0]    prod_full;

    assign sel       = step_reg[1:0];
    assign prod_full = PROD_W'(em_reg[sel]) * PROD_W'(cfg.stride[sel]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(NUM_AXES))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // The product is registered; it is added in the cycle after it is formed.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            em_reg  <= coords;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg < STEP_W'(NUM_AXES))
            begin
                prod_reg <= OFFSET_W'(prod_full);
            end
            if (step_reg != '0)
            begin
                acc_reg <= acc_reg + prod_reg;
            end
        end
    end

    assign busy      = busy_reg;
    assign em_coords = em_reg;
    assign acc       = acc_reg;

endmodule

`default_nettype wire

[hdl/diagonal_scan_order_4d_unit.sv]
// Top level of the 4D diagonal scan order unit: sequencer, output register
// and the instances of dso4_cfg, dso4_walk and dso4_mac. Depends on dso4_pkg.
//
// Each request on the input channel (in_valid/in_ready, field restart) yields
// exactly one result on the output channel (out_valid/out_ready): the next
// in-range position of the scan with its linear offset, and last set on the
// final position, after which the scan wraps to the origin. restart = 1 starts
// again from the origin. The walk unit visits one tuple per cycle while the
// sequencer searches. The time to a result grows with the tuples skipped before
// the emitted position and before the following one; that skipping sets the
// rate. The offset is formed by one shared multiplier, overlapped with the
// search for the following position. in_ready is high only while the sequencer
// is idle and returns the cycle after a result is loaded, so a new request is
// not accepted until the last result is loaded. A finished result sits in the
// output register; if the receiver stalls, the next request is still accepted
// and worked on, and the block waits only before loading its result. Reset puts
// the scan at the origin and the registers at sizes 15, 15, 13, 13 and strides
// 1, 15, 225, 2925. The user must write registers over the APB-style port only
// while no request is open; the block itself does not enforce it.
`default_nettype none

module diagonal_scan_order_4d_unit (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [dso4_pkg::ADDR_W-1:0]   paddr,
    input  wire  [dso4_pkg::DATA_W-1:0]   pwdata,
    output logic [dso4_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire                           restart,
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic [dso4_pkg::OFFSET_W-1:0] offset,
    output logic [dso4_pkg::COORD_W-1:0]  coord_x,
    output logic [dso4_pkg::COORD_W-1:0]  coord_y,
    output logic [dso4_pkg::COORD_W-1:0]  coord_u,
    output logic [dso4_pkg::COORD_W-1:0]  coord_v,
    output logic                          last
);
    import dso4_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEEK1  = 2'd1;
    localparam logic [1:0] S_SEEK2  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    cfg_t                 cfg;
    walk_cmd_t            wcmd;
    walk_stat_t           wstat;
    coord_vec_t           wpos;
    coord_vec_t           em_coords;
    logic                 mac_start;
    logic                 mac_busy;
    logic [OFFSET_W-1:0]  mac_acc;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic                 last_flag_reg;
    logic                 last_flag_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_load;
    logic [OFFSET_W-1:0]  offset_reg;
    logic [NUM_AXES-1:0][COORD_W-1:0] coord_reg;
    logic                 last_reg;

    dso4_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dso4_walk u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cmd   (wcmd),
        .pos   (wpos),
        .stat  (wstat)
    );

    dso4_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mac_start),
        .coords    (wpos),
        .cfg       (cfg),
        .busy      (mac_busy),
        .em_coords (em_coords),
        .acc       (mac_acc)
    );

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        last_flag_next = last_flag_reg;
        wcmd.op        = WOP_HOLD;
        mac_start      = 1'b0;
        out_load       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (restart)
                    begin
                        wcmd.op = WOP_ZERO;
                    end
                    state_next = S_SEEK1;
                end
            end
            S_SEEK1:
            begin
                // Find the position to emit; running past the end falls back
                // to the origin, which is always in range.
                priority if (wstat.in_range)
                begin
                    mac_start  = 1'b1;
                    wcmd.op    = WOP_STEP;
                    state_next = S_SEEK2;
                end
                else if (wstat.over)
                begin
                    wcmd.op = WOP_ZERO;
                end
                else
                begin
                    wcmd.op = WOP_STEP;
                end
            end
            S_SEEK2:
            begin
                priority if (wstat.in_range)
                begin
                    last_flag_next = 1'b0;
                    state_next     = S_FINISH;
                end
                else if (wstat.over)
                begin
                    wcmd.op        = WOP_ZERO;
                    last_flag_next = 1'b1;
                    state_next     = S_FINISH;
                end
                else
                begin
                    wcmd.op = WOP_STEP;
                end
            end
            S_FINISH:
            begin
                if (!mac_busy && (!out_valid_reg || out_ready))
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            last_flag_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_flag_reg <= last_flag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            offset_reg <= mac_acc;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                coord_reg[i] <= em_coords[i][COORD_W-1:0];
            end
            last_reg <= last_flag_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign offset    = offset_reg;
    assign coord_x   = coord_reg[0];
    assign coord_y   = coord_reg[1];
    assign coord_u   = coord_reg[2];
    assign coord_v   = coord_reg[3];
    assign last      = last_reg;

    // The search always leaves the walk on an in-range position.
    a_finish_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |-> wstat.in_range)
        else $error("walk left out of range after search");

    // The final position of a scan leaves the walk at the origin.
    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && last_flag_reg) |-> (wpos == '0))
        else $error("scan end did not wrap to the origin");

    // The offset unit is never restarted while it is still summing.
    a_mac_free: assert property (@(posedge clk) disable iff (!rst_n)
        mac_start |-> !mac_busy)
        else $error("offset unit started while busy");

    // A result is loaded only once the offset sum is complete.
    a_load_after_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (out_valid_reg && !mac_busy))
        else $error("result loaded before offset was complete");

endmodule

`default_nettype wire
